[rtl/core/multichannel_audio_ring_buffer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel audio ring buffer unit
// Shared property wrappers, clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_AUDIO_RING_BUFFER_UNIT_MACROS_SVH
`define MULTICHANNEL_AUDIO_RING_BUFFER_UNIT_MACROS_SVH

// Property checked only while out of reset
`define MARBU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included
`define MARBU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/marbu_pkg.sv]
// ----------------------------------------------------------------------------
// marbu_pkg
// Types, constants and helpers shared by the audio ring buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package marbu_pkg;

  localparam int RING_DEPTH  = 4096;
  localparam int ADDR_W      = $clog2(RING_DEPTH);
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_W    = 24;
  localparam int CNT_W       = 48;
  localparam int MAX_BLOCK   = 64;
  localparam int BLK_W       = 7;
  localparam int CFG_W       = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CHAN_LIM = 2'((CHANNELS < 2) ? CHANNELS : 2);

  typedef enum logic [1:0] {
    FUNC_WR_Q23   = 2'd0,
    FUNC_WR_S16   = 2'd1,
    FUNC_RD_BLOCK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CFG_RING_CH = 2'd0,
    CFG_OUT_CH  = 2'd1,
    CFG_BLK_LEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ
  } back_state_t;

  // One queued operation: a frame write or a block read
  typedef struct packed {
    logic                is_read;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data_a;
    logic [SAMPLE_W-1:0] data_b;
    logic                we_a;
    logic                we_b;
    logic [BLK_W-1:0]    nblk;
    logic [1:0]          nch;
    logic                ok;
  } cmd_t;

  // Clamp a channel register into 1..CHAN_LIM
  function automatic logic [1:0] chan_limit(input logic [1:0] v);
    logic [1:0] res;
    if (v == 2'd0) begin
      res = 2'd1;
    end else if (v > CHAN_LIM) begin
      res = CHAN_LIM;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[rtl/core/marbu_ram.sv]
// ----------------------------------------------------------------------------
// marbu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marbu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/marbu_front.sv]
// ----------------------------------------------------------------------------
// marbu_front
// Accepts commands, holds configuration and frame counters, and turns each
// command into a queued write or a block read with its underrun decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marbu_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [1:0]                    in_frame_channels,
  input  logic signed [marbu_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic signed [marbu_pkg::SAMPLE_W-1:0] in_sample_b,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [marbu_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          push,
  output marbu_pkg::cmd_t               cmd
);

  logic [1:0]                  ring_ch_r;
  logic [1:0]                  out_ch_r;
  logic [marbu_pkg::BLK_W-1:0] blk_r;
  logic [marbu_pkg::CNT_W-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [marbu_pkg::CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;

  logic                        accept;
  logic [1:0]                  rc_eff, oc_eff;
  logic [marbu_pkg::BLK_W-1:0] nblk;
  logic                        ok;
  logic                        is_wr, is_rd;

  assign cfg_ready = 1'b1;
  assign busy      = q_full | clearing;
  assign accept    = start & ~busy;

  assign rc_eff = marbu_pkg::chan_limit(ring_ch_r);
  assign oc_eff = marbu_pkg::chan_limit(out_ch_r);

  always_comb begin
    if (blk_r == '0) begin
      nblk = marbu_pkg::BLK_W'(1);
    end else if (blk_r > marbu_pkg::BLK_W'(marbu_pkg::MAX_BLOCK)) begin
      nblk = marbu_pkg::BLK_W'(marbu_pkg::MAX_BLOCK);
    end else begin
      nblk = blk_r;
    end
  end

  // Enough frames only if the writer is ahead by at least one block
  assign ok = (wr_cnt_r >= rd_cnt_r) &&
              ((wr_cnt_r - rd_cnt_r) >= marbu_pkg::CNT_W'(nblk));

  always_comb begin
    is_wr = 1'b0;
    is_rd = 1'b0;
    case (marbu_pkg::func_t'(in_func))
      marbu_pkg::FUNC_WR_Q23,
      marbu_pkg::FUNC_WR_S16:   is_wr = 1'b1;
      marbu_pkg::FUNC_RD_BLOCK: is_rd = 1'b1;
      default: begin
        is_wr = 1'b0;
        is_rd = 1'b0;
      end
    endcase
  end

  assign push = accept & (is_wr | is_rd);

  always_comb begin
    cmd         = '0;
    cmd.is_read = is_rd;
    cmd.nblk    = nblk;
    cmd.nch     = (oc_eff < rc_eff) ? oc_eff : rc_eff;
    cmd.ok      = ok;
    if (is_rd) begin
      cmd.addr = rd_cnt_r[marbu_pkg::ADDR_W-1:0];
    end else begin
      cmd.addr = wr_cnt_r[marbu_pkg::ADDR_W-1:0];
    end
    if (marbu_pkg::func_t'(in_func) == marbu_pkg::FUNC_WR_S16) begin
      cmd.data_a = {in_sample_a[15:0], 8'd0};
      cmd.data_b = {in_sample_b[15:0], 8'd0};
    end else begin
      cmd.data_a = in_sample_a;
      cmd.data_b = in_sample_b;
    end
    // Store only min(frame channels, ring channels)
    cmd.we_a = is_wr & (in_frame_channels != 2'd0);
    cmd.we_b = is_wr & (in_frame_channels >= 2'd2) & (rc_eff >= 2'd2);
  end

  always_comb begin
    wr_cnt_nxt = wr_cnt_r;
    rd_cnt_nxt = rd_cnt_r;
    if (accept && is_wr) begin
      wr_cnt_nxt = wr_cnt_r + marbu_pkg::CNT_W'(1);
    end
    if (accept && is_rd && ok) begin
      rd_cnt_nxt = rd_cnt_r + marbu_pkg::CNT_W'(nblk);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_ch_r <= 2'd2;
      out_ch_r  <= 2'd2;
      blk_r     <= marbu_pkg::BLK_W'(marbu_pkg::MAX_BLOCK);
      wr_cnt_r  <= '0;
      rd_cnt_r  <= '0;
    end else begin
      wr_cnt_r <= wr_cnt_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (cfg_valid) begin
        case (marbu_pkg::cfg_idx_t'(cfg_index))
          marbu_pkg::CFG_RING_CH: ring_ch_r <= cfg_data[1:0];
          marbu_pkg::CFG_OUT_CH:  out_ch_r  <= cfg_data[1:0];
          marbu_pkg::CFG_BLK_LEN: blk_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/core/marbu_cmdq.sv]
// ----------------------------------------------------------------------------
// marbu_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marbu_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  marbu_pkg::cmd_t push_cmd,
  input  logic            pop,
  output marbu_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);

  marbu_pkg::cmd_t               slot_r [marbu_pkg::QUEUE_DEPTH];
  logic [marbu_pkg::QPTR_W-1:0]  wp_r, rp_r;
  logic [marbu_pkg::QPTR_W:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (marbu_pkg::QPTR_W+1)'(marbu_pkg::QUEUE_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

endmodule

[rtl/core/marbu_back.sv]
// ----------------------------------------------------------------------------
// marbu_back
// Executes queued commands against the sample store: clears it after reset,
// writes frames, and streams read blocks one frame per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marbu_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  marbu_pkg::cmd_t                       head,
  input  logic                                  q_empty,
  output logic                                  pop,
  output logic                                  clearing,
  output logic                                  out_valid,
  output logic signed [marbu_pkg::SAMPLE_W-1:0] out_a,
  output logic signed [marbu_pkg::SAMPLE_W-1:0] out_b,
  output logic [1:0]                            out_channel_count,
  output logic                                  out_underrun,
  output logic                                  out_last
);

  marbu_pkg::back_state_t state_r, state_nxt;

  logic [marbu_pkg::ADDR_W-1:0]   clr_r;
  marbu_pkg::cmd_t                cur_r;
  logic [marbu_pkg::BLK_W-1:0]    s_r;
  logic                           pv_r;
  logic                           p_last_r;
  logic                           p_ok_r;
  logic [1:0]                     p_nch_r;

  logic [marbu_pkg::ADDR_W-1:0]   ram_addr;
  logic                           we_a, we_b;
  logic [marbu_pkg::SAMPLE_W-1:0] wd_a, wd_b;
  logic [marbu_pkg::SAMPLE_W-1:0] rd_a, rd_b;
  logic                           issue, load, last_frame;

  assign last_frame = (s_r == cur_r.nblk - marbu_pkg::BLK_W'(1));
  assign clearing   = (state_r == marbu_pkg::BK_CLEAR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      marbu_pkg::BK_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = marbu_pkg::BK_IDLE;
        end
      end
      marbu_pkg::BK_IDLE: begin
        if (!q_empty && head.is_read) begin
          state_nxt = marbu_pkg::BK_READ;
        end
      end
      marbu_pkg::BK_READ: begin
        if (last_frame) begin
          state_nxt = marbu_pkg::BK_IDLE;
        end
      end
      default: state_nxt = marbu_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load     = 1'b0;
    issue    = 1'b0;
    we_a     = 1'b0;
    we_b     = 1'b0;
    wd_a     = '0;
    wd_b     = '0;
    ram_addr = cur_r.addr + marbu_pkg::ADDR_W'(s_r);
    case (state_r)
      marbu_pkg::BK_CLEAR: begin
        ram_addr = clr_r;
        we_a     = 1'b1;
        we_b     = 1'b1;
      end
      marbu_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.is_read) begin
            load = 1'b1;
          end else begin
            ram_addr = head.addr;
            we_a     = head.we_a;
            we_b     = head.we_b;
            wd_a     = head.data_a;
            wd_b     = head.data_b;
          end
        end
      end
      marbu_pkg::BK_READ: begin
        issue = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= marbu_pkg::BK_CLEAR;
      clr_r   <= '0;
      s_r     <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (clearing) begin
        clr_r <= clr_r + 1'b1;
      end
      if (load) begin
        s_r <= '0;
      end else if (issue) begin
        s_r <= s_r + 1'b1;
      end
    end
  end

  // Frame metadata, aligned with the registered RAM read
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= head;
    end
    p_last_r <= last_frame;
    p_ok_r   <= cur_r.ok;
    p_nch_r  <= cur_r.nch;
  end

  marbu_ram #(
    .WIDTH(marbu_pkg::SAMPLE_W),
    .DEPTH(marbu_pkg::RING_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .addr  (ram_addr),
    .wdata (wd_a),
    .rdata (rd_a)
  );

  marbu_ram #(
    .WIDTH(marbu_pkg::SAMPLE_W),
    .DEPTH(marbu_pkg::RING_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .addr  (ram_addr),
    .wdata (wd_b),
    .rdata (rd_b)
  );

  assign out_valid         = pv_r;
  assign out_a             = p_ok_r ? rd_a : '0;
  assign out_b             = (p_ok_r && (p_nch_r >= 2'd2)) ? rd_b : '0;
  assign out_channel_count = p_nch_r;
  assign out_underrun      = ~p_ok_r;
  assign out_last          = p_last_r;

endmodule

[rtl/core/multichannel_audio_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_audio_ring_buffer_unit
// Two-channel Q1.23 sample ring with frame writes and block reads.
//
//   Channel   Direction  Handshake              Word
//   command   in         start / busy           func, frame_channels, samples
//   result    out        out_valid strobe       one frame of a read block
//   config    in         cfg_valid / cfg_ready  register index and value
//
// The front takes one command per cycle while the four-entry command queue
// has room. The back does a frame write as one store write, and a block read
// as a load step then one store read per frame, bounded by the single store
// port; results follow one frame per cycle, in the cycle after each store read.
// After reset the store is cleared, all 4096 entries, with busy high.
// Results are strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_audio_ring_buffer_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_func,
  input  logic [1:0]                            in_frame_channels,
  input  logic signed [marbu_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic signed [marbu_pkg::SAMPLE_W-1:0] in_sample_b,
  output logic                                  out_valid,
  output logic signed [marbu_pkg::SAMPLE_W-1:0] out_a,
  output logic signed [marbu_pkg::SAMPLE_W-1:0] out_b,
  output logic [1:0]                            out_channel_count,
  output logic                                  out_underrun,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [marbu_pkg::CFG_W-1:0]           cfg_data
);

  marbu_pkg::cmd_t push_cmd, head;
  logic            push, pop, q_empty, q_full, clearing;

  marbu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_frame_channels (in_frame_channels),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .clearing          (clearing),
    .push              (push),
    .cmd               (push_cmd)
  );

  marbu_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  marbu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_empty           (q_empty),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_a             (out_a),
    .out_b             (out_b),
    .out_channel_count (out_channel_count),
    .out_underrun      (out_underrun),
    .out_last          (out_last)
  );

endmodule

[rtl/core/marbu_checker.sv]
// ----------------------------------------------------------------------------
// marbu_checker
// Port-level checks on result words and reset behavior, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multichannel_audio_ring_buffer_unit_macros.svh"

module marbu_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic signed [marbu_pkg::SAMPLE_W-1:0] out_a,
  input logic signed [marbu_pkg::SAMPLE_W-1:0] out_b,
  input logic [1:0]                            out_channel_count,
  input logic                                  out_underrun,
  input logic                                  out_last
);

  `MARBU_ASSERT_RST(a_reset_clears, !rst_n |=> (busy && !out_valid), "reset did not start clearing")
  `MARBU_ASSERT(a_underrun_silent, (out_valid && out_underrun) |-> (out_a == '0 && out_b == '0), "underrun word not silent")
  `MARBU_ASSERT(a_mono_b_zero, (out_valid && out_channel_count == 2'd1) |-> (out_b == '0), "inactive channel not zero")
  `MARBU_ASSERT(a_count_legal, out_valid |-> (out_channel_count == 2'd1 || out_channel_count == 2'd2), "bad channel count")
  `MARBU_ASSERT(a_block_gap, (out_valid && out_last) |=> !out_valid, "block not closed after last word")

endmodule

bind multichannel_audio_ring_buffer_unit marbu_checker u_marbu_checker (.*);

[tb/tb_multichannel_audio_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// tb_multichannel_audio_ring_buffer_unit
// Drives frame writes, block reads and unused commands into the sample ring.
// A scoreboard class keeps its own copy of the ring, counters and registers,
// predicts every result word and checks each strobed word in order.
// Register settings change between phases while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multichannel_audio_ring_buffer_unit;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;
  localparam int         DRAIN_WAIT  = 16;

  typedef struct packed {
    logic signed [marbu_pkg::SAMPLE_W-1:0] a;
    logic signed [marbu_pkg::SAMPLE_W-1:0] b;
    logic [1:0]                            chans;
    logic                                  underrun;
    logic                                  last;
  } ring_frame_t;

  class ring_scoreboard;
    logic [2*marbu_pkg::SAMPLE_W-1:0] frames [marbu_pkg::RING_DEPTH];
    logic [marbu_pkg::CNT_W-1:0]      wr_cnt;
    logic [marbu_pkg::CNT_W-1:0]      rd_cnt;
    logic [1:0]                       ring_reg;
    logic [1:0]                       out_reg;
    logic [marbu_pkg::BLK_W-1:0]      blk_reg;
    ring_frame_t                      expected_frames [$];
    int                               errors;

    function new();
      for (int k = 0; k < marbu_pkg::RING_DEPTH; k++) frames[k] = '0;
      wr_cnt   = '0;
      rd_cnt   = '0;
      ring_reg = 2'd2;
      out_reg  = 2'd2;
      blk_reg  = 7'd64;
      errors   = 0;
    endfunction

    function int chan_clamp(logic [1:0] v);
      int lim;
      lim = (marbu_pkg::CHANNELS < 2) ? marbu_pkg::CHANNELS : 2;
      if (lim < 1) lim = 1;
      if (v == 2'd0) return 1;
      return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function int block_frames();
      if (blk_reg == '0) return 1;
      return (int'(blk_reg) > marbu_pkg::MAX_BLOCK) ? marbu_pkg::MAX_BLOCK : int'(blk_reg);
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [marbu_pkg::CFG_W-1:0] v);
      case (idx)
        marbu_pkg::CFG_RING_CH: ring_reg = v[1:0];
        marbu_pkg::CFG_OUT_CH:  out_reg  = v[1:0];
        marbu_pkg::CFG_BLK_LEN: blk_reg  = v[marbu_pkg::BLK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [1:0] f, logic [1:0] fch,
                               logic [marbu_pkg::SAMPLE_W-1:0] a,
                               logic [marbu_pkg::SAMPLE_W-1:0] b);
      int                               lim;
      int                               n;
      int                               nblk;
      int                               nch;
      logic [marbu_pkg::SAMPLE_W-1:0]   sam_a;
      logic [marbu_pkg::SAMPLE_W-1:0]   sam_b;
      logic [marbu_pkg::ADDR_W-1:0]     slot;
      logic [marbu_pkg::CNT_W-1:0]      pos;
      logic [marbu_pkg::CNT_W-1:0]      avail;
      logic [2*marbu_pkg::SAMPLE_W-1:0] entry;
      bit                               ok;
      ring_frame_t                      fr;
      case (f)
        marbu_pkg::FUNC_WR_Q23, marbu_pkg::FUNC_WR_S16: begin
          lim  = chan_clamp(ring_reg);
          n    = (int'(fch) < lim) ? int'(fch) : lim;
          slot = wr_cnt[marbu_pkg::ADDR_W-1:0];
          if (f == marbu_pkg::FUNC_WR_Q23) begin
            sam_a = a;
            sam_b = b;
          end else begin
            // widen the low 16 bits to Q1.23
            sam_a = {a[15:0], 8'h00};
            sam_b = {b[15:0], 8'h00};
          end
          if (n >= 1) frames[slot][marbu_pkg::SAMPLE_W-1:0] = sam_a;
          if (n >= 2) frames[slot][2*marbu_pkg::SAMPLE_W-1:marbu_pkg::SAMPLE_W] = sam_b;
          wr_cnt = wr_cnt + 1'b1;
        end
        marbu_pkg::FUNC_RD_BLOCK: begin
          nblk  = block_frames();
          nch   = chan_clamp(out_reg);
          if (chan_clamp(ring_reg) < nch) nch = chan_clamp(ring_reg);
          avail = (wr_cnt >= rd_cnt) ? (wr_cnt - rd_cnt) : '0;
          ok    = (avail >= marbu_pkg::CNT_W'(nblk));
          for (int k = 0; k < nblk; k++) begin
            pos         = rd_cnt + marbu_pkg::CNT_W'(k);
            entry       = frames[pos[marbu_pkg::ADDR_W-1:0]];
            fr.a        = ok ? entry[marbu_pkg::SAMPLE_W-1:0] : '0;
            fr.b        = (ok && nch >= 2) ?
                          entry[2*marbu_pkg::SAMPLE_W-1:marbu_pkg::SAMPLE_W] : '0;
            fr.chans    = 2'(nch);
            fr.underrun = !ok;
            fr.last     = (k == nblk - 1);
            expected_frames.push_back(fr);
          end
          // hold the read pointer on underrun
          if (ok) rd_cnt = rd_cnt + marbu_pkg::CNT_W'(nblk);
        end
        default: ;
      endcase
    endfunction

    function void check_frame(ring_frame_t got);
      ring_frame_t want;
      if (expected_frames.size() == 0) begin
        $error("result word with nothing expected: out_a %0d out_b %0d", got.a, got.b);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.a !== want.a) begin
        $error("out_a: expected %0d, actual %0d", want.a, got.a);
        errors++;
      end
      if (got.b !== want.b) begin
        $error("out_b: expected %0d, actual %0d", want.b, got.b);
        errors++;
      end
      if (got.chans !== want.chans) begin
        $error("out_channel_count: expected %0d, actual %0d", want.chans, got.chans);
        errors++;
      end
      if (got.underrun !== want.underrun) begin
        $error("out_underrun: expected %0d, actual %0d", want.underrun, got.underrun);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                                  clk = 1'b0;
  logic                                  rst_n;
  logic                                  start;
  logic                                  busy;
  logic [1:0]                            in_func;
  logic [1:0]                            in_frame_channels;
  logic signed [marbu_pkg::SAMPLE_W-1:0] in_sample_a;
  logic signed [marbu_pkg::SAMPLE_W-1:0] in_sample_b;
  logic                                  out_valid;
  logic signed [marbu_pkg::SAMPLE_W-1:0] out_a;
  logic signed [marbu_pkg::SAMPLE_W-1:0] out_b;
  logic [1:0]                            out_channel_count;
  logic                                  out_underrun;
  logic                                  out_last;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [1:0]                            cfg_index;
  logic [marbu_pkg::CFG_W-1:0]           cfg_data;

  ring_scoreboard sb = new();
  int             sender_idle = 0;

  multichannel_audio_ring_buffer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_frame_channels (in_frame_channels),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .out_valid         (out_valid),
    .out_a             (out_a),
    .out_b             (out_b),
    .out_channel_count (out_channel_count),
    .out_underrun      (out_underrun),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_frame('{out_a, out_b, out_channel_count, out_underrun, out_last});
    end
  end

  initial begin
    #500000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [marbu_pkg::SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return {r[23:16], 16'h7FFF};
      4: return {r[23:16], 16'h8000};
      default: return r[marbu_pkg::SAMPLE_W-1:0];
    endcase
  endfunction

  // Present one command word; start stays high after acceptance.
  task automatic push_cmd(input logic [1:0] f, input logic [1:0] fch,
                          input logic [marbu_pkg::SAMPLE_W-1:0] a,
                          input logic [marbu_pkg::SAMPLE_W-1:0] b);
    int gap;
    gap = 0;
    // each idle cycle is drawn with the sender's idle odds
    while (sender_idle > 0 && $urandom_range(0, 99) < sender_idle) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_func           <= f;
    in_frame_channels <= fch;
    in_sample_a       <= a;
    in_sample_b       <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(f, fch, a, b);
  endtask

  task automatic push_random_write();
    logic [1:0] f;
    logic [1:0] fch;
    f   = $urandom_range(0, 1) ? marbu_pkg::FUNC_WR_S16 : marbu_pkg::FUNC_WR_Q23;
    fch = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd2;
    push_cmd(f, fch, pick_sample(), pick_sample());
  endtask

  task automatic push_read();
    push_cmd(marbu_pkg::FUNC_RD_BLOCK, 2'($urandom_range(0, 3)), pick_sample(), pick_sample());
  endtask

  // Drop start and wait out every expected word plus the write backlog.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_config(input logic [marbu_pkg::CFG_W-1:0] ring_v,
                             input logic [marbu_pkg::CFG_W-1:0] out_v,
                             input logic [marbu_pkg::CFG_W-1:0] blk_v,
                             input bit poke_spare);
    logic [1:0]                  idx [4];
    logic [marbu_pkg::CFG_W-1:0] val [4];
    int                          first;
    idx[0] = CFG_UNUSED;             val[0] = marbu_pkg::CFG_W'($urandom());
    idx[1] = marbu_pkg::CFG_RING_CH; val[1] = ring_v;
    idx[2] = marbu_pkg::CFG_OUT_CH;  val[2] = out_v;
    idx[3] = marbu_pkg::CFG_BLK_LEN; val[3] = blk_v;
    first = poke_spare ? 0 : 1;
    for (int k = first; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Bursts of writes closed by a read; short bursts leave the reader starved.
  task automatic run_phase(input int budget, input int idle);
    int sent;
    int burst;
    int nb;
    sent        = 0;
    sender_idle = idle;
    while (sent < budget) begin
      nb    = sb.block_frames();
      burst = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(nb / 2, nb + 2);
      for (int k = 0; k < burst && sent < budget; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_cmd(FUNC_UNUSED, 2'($urandom_range(0, 3)), pick_sample(), pick_sample());
        end else begin
          push_random_write();
          sent++;
        end
      end
      push_read();
      sent++;
    end
    drain();
  endtask

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_func           <= marbu_pkg::FUNC_WR_Q23;
    in_frame_channels <= 2'd0;
    in_sample_a       <= '0;
    in_sample_b       <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= marbu_pkg::CFG_RING_CH;
    cfg_data          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty ring gives a full silent block
    push_read();
    drain();
    load_config(7'd2, 7'd2, 7'd4, 1'b0);
    push_cmd(marbu_pkg::FUNC_WR_Q23, 2'd2, 24'h7FFFFF, 24'h800000);
    push_cmd(marbu_pkg::FUNC_WR_S16, 2'd2, 24'hFF7FFF, 24'h008000);
    push_cmd(marbu_pkg::FUNC_WR_Q23, 2'd1, 24'h000000, 24'hFFFFFF);
    push_cmd(marbu_pkg::FUNC_WR_Q23, 2'd0, 24'hFFFFFF, 24'hFFFFFF);
    push_cmd(FUNC_UNUSED, 2'd3, 24'hFFFFFF, 24'hFFFFFF);
    push_read();
    push_read();
    push_cmd(marbu_pkg::FUNC_WR_S16, 2'd3, 24'h00FFFF, 24'h7F8000);
    push_cmd(marbu_pkg::FUNC_WR_S16, 2'd1, 24'h123456, 24'hABCDEF);
    push_cmd(marbu_pkg::FUNC_WR_S16, 2'd0, 24'h555555, 24'hAAAAAA);
    push_cmd(marbu_pkg::FUNC_WR_Q23, 2'd3, 24'h123456, 24'hEDCBA9);
    push_read();
    drain();

    load_config(7'd2, 7'd2, 7'd6, 1'b0);
    run_phase(35, 30);
    load_config(7'h7D, 7'd2, 7'd1, 1'b0);
    run_phase(25, 30);
    load_config(7'd2, 7'h05, 7'd11, 1'b1);
    run_phase(35, 45);
    load_config(7'h40, 7'd3, 7'd0, 1'b0);
    run_phase(25, 45);
    load_config(7'd3, 7'h00, 7'd127, 1'b0);
    run_phase(70, 0);

    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
